### design/vnig_pkg.sv
// Shared types, constants and neighbour tables for the voxel neighbour index generator.
package vnig_pkg;

    localparam int COORD_BITS = 10;
    localparam int SIZE_W     = 11;
    localparam int IDX_W      = 30;
    localparam int CMD_W      = 3;
    localparam int EFF_W      = COORD_BITS + 1;
    localparam int SXY_W      = 2 * COORD_BITS + 1;
    localparam int TOT_W      = 3 * COORD_BITS + 1;
    localparam int CMP_W      = (TOT_W > IDX_W) ? TOT_W : IDX_W;
    localparam int DIV_W      = 3 * COORD_BITS;
    localparam int DIV_CNT_W  = $clog2(COORD_BITS + 1);
    localparam int NBR_MAX    = 27;
    localparam int NBR_IDX_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int S_DATA_W   = 32;
    localparam int S_USER_W   = CMD_W;
    localparam int M_DATA_W   = 32;
    localparam int M_USER_W   = 2;

    // modes
    localparam logic [CMD_W-1:0] MODE_FACES   = 3'd0;
    localparam logic [CMD_W-1:0] MODE_BOX     = 3'd1;
    localparam logic [CMD_W-1:0] MODE_RING_XY = 3'd2;
    localparam logic [CMD_W-1:0] MODE_RING_YZ = 3'd3;
    localparam logic [CMD_W-1:0] MODE_RING_XZ = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    typedef enum logic [1:0] {
        D_ZERO = 2'd0,
        D_POS  = 2'd1,
        D_NEG  = 2'd2
    } dir_t;

    typedef struct packed {
        dir_t dx;
        dir_t dy;
        dir_t dz;
    } offs_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_TOT,
        F_CHK,
        F_DIVZ,
        F_DIVY,
        F_PUSH
    } front_state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     num;
        logic [SXY_W-1:0]     den;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [COORD_BITS-1:0] quo;
        logic [DIV_W-1:0]      rem;
    } div_rsp_t;

    // one classified item as handed from front to back
    typedef struct packed {
        logic                 oog;
        logic [CMD_W-1:0]     cmd;
        logic [IDX_W-1:0]     idx;
        logic [NBR_MAX-1:0]   mask;
        logic [EFF_W-1:0]     sx;
        logic [SXY_W-1:0]     sxy;
    } job_t;

    // register value clamped to 1 .. 2^COORD_BITS
    function automatic logic [EFF_W-1:0] eff_size(logic [SIZE_W-1:0] r);
        logic [SIZE_W+EFF_W-1:0] v;
        logic [SIZE_W+EFF_W-1:0] lim;
        v   = (SIZE_W+EFF_W)'(r);
        lim = (SIZE_W+EFF_W)'(1) << COORD_BITS;
        if (v == '0) begin
            v = (SIZE_W+EFF_W)'(1);
        end
        if (v > lim) begin
            v = lim;
        end
        return EFF_W'(v);
    endfunction

    function automatic logic [NBR_IDX_W-1:0] nbr_count(logic [CMD_W-1:0] cmd);
        logic [NBR_IDX_W-1:0] n;
        case (cmd)
            MODE_FACES:   n = NBR_IDX_W'(6);
            MODE_BOX:     n = NBR_IDX_W'(27);
            MODE_RING_XY,
            MODE_RING_YZ,
            MODE_RING_XZ: n = NBR_IDX_W'(8);
            default:      n = '0;
        endcase
        return n;
    endfunction

    // eight-ring order, first coordinate in dx, second in dy
    function automatic offs_t ring_offs(logic [2:0] i);
        offs_t o;
        o = '{dx: D_ZERO, dy: D_ZERO, dz: D_ZERO};
        case (i)
            3'd0: o.dx = D_NEG;
            3'd1: begin o.dx = D_NEG;  o.dy = D_NEG; end
            3'd2: o.dy = D_NEG;
            3'd3: begin o.dx = D_POS;  o.dy = D_NEG; end
            3'd4: o.dx = D_POS;
            3'd5: begin o.dx = D_POS;  o.dy = D_POS; end
            3'd6: o.dy = D_POS;
            3'd7: begin o.dx = D_NEG;  o.dy = D_POS; end
            default: o.dx = D_ZERO;
        endcase
        return o;
    endfunction

    // in-layer order of the box
    function automatic offs_t box_offs(logic [3:0] i);
        offs_t o;
        o = '{dx: D_ZERO, dy: D_ZERO, dz: D_ZERO};
        case (i)
            4'd0: o.dx = D_ZERO;
            4'd1: o.dy = D_NEG;
            4'd2: o.dy = D_POS;
            4'd3: o.dx = D_NEG;
            4'd4: begin o.dx = D_NEG; o.dy = D_NEG; end
            4'd5: begin o.dx = D_NEG; o.dy = D_POS; end
            4'd6: o.dx = D_POS;
            4'd7: begin o.dx = D_POS; o.dy = D_NEG; end
            4'd8: begin o.dx = D_POS; o.dy = D_POS; end
            default: o.dx = D_ZERO;
        endcase
        return o;
    endfunction

    function automatic offs_t nbr_offs(logic [CMD_W-1:0] cmd, logic [NBR_IDX_W-1:0] k);
        offs_t o;
        offs_t r;
        o = '{dx: D_ZERO, dy: D_ZERO, dz: D_ZERO};
        r = ring_offs(k[2:0]);
        case (cmd)
            MODE_FACES: begin
                case (k)
                    NBR_IDX_W'(0): o.dx = D_NEG;
                    NBR_IDX_W'(1): o.dx = D_POS;
                    NBR_IDX_W'(2): o.dy = D_NEG;
                    NBR_IDX_W'(3): o.dy = D_POS;
                    NBR_IDX_W'(4): o.dz = D_NEG;
                    NBR_IDX_W'(5): o.dz = D_POS;
                    default:       o.dx = D_ZERO;
                endcase
            end
            MODE_BOX: begin
                // layers dz = 0, -1, +1
                if (k < NBR_IDX_W'(9)) begin
                    o = box_offs(k[3:0]);
                end else if (k < NBR_IDX_W'(18)) begin
                    o    = box_offs(4'(k - NBR_IDX_W'(9)));
                    o.dz = D_NEG;
                end else begin
                    o    = box_offs(4'(k - NBR_IDX_W'(18)));
                    o.dz = D_POS;
                end
            end
            MODE_RING_XY: begin
                o.dx = r.dx;
                o.dy = r.dy;
            end
            MODE_RING_YZ: begin
                o.dz = r.dx;
                o.dy = r.dy;
            end
            MODE_RING_XZ: begin
                o.dz = r.dx;
                o.dx = r.dy;
            end
            default: o.dx = D_ZERO;
        endcase
        return o;
    endfunction

    function automatic logic coord_ok(dir_t d, logic [COORD_BITS-1:0] c,
                                      logic [EFF_W-1:0] s);
        logic ok;
        case (d)
            D_NEG:   ok = (c != '0);
            D_POS:   ok = ((EFF_W'(c) + EFF_W'(1)) < s);
            D_ZERO:  ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic nbr_in_grid(logic [CMD_W-1:0] cmd, logic [NBR_IDX_W-1:0] k,
                                         logic [COORD_BITS-1:0] x,
                                         logic [COORD_BITS-1:0] y,
                                         logic [COORD_BITS-1:0] z,
                                         logic [EFF_W-1:0] sx,
                                         logic [EFF_W-1:0] sy,
                                         logic [EFF_W-1:0] sz);
        offs_t o;
        o = nbr_offs(cmd, k);
        return (k < nbr_count(cmd)) && coord_ok(o.dx, x, sx) &&
               coord_ok(o.dy, y, sy) && coord_ok(o.dz, z, sz);
    endfunction

endpackage

### design/vnig_div.sv
// Restoring divider, one quotient bit per cycle, quotient known to fit COORD_BITS.
module vnig_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  vnig_pkg::div_req_t req,
    output vnig_pkg::div_rsp_t rsp
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [vnig_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic [vnig_pkg::DIV_W-1:0]          rem_reg;
    logic [vnig_pkg::DIV_W-1:0]          dsh_reg;
    logic [vnig_pkg::COORD_BITS-1:0]     quo_reg;
    logic                                ge;
    logic [vnig_pkg::DIV_W-1:0]          diff;

    assign ge   = (rem_reg >= dsh_reg);
    assign diff = rem_reg - dsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= vnig_pkg::DIV_CNT_W'(vnig_pkg::COORD_BITS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - vnig_pkg::DIV_CNT_W'(1);
            if (cnt_reg == vnig_pkg::DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.num;
            // divisor aligned to the top quotient bit
            dsh_reg <= vnig_pkg::DIV_W'(req.den) << (vnig_pkg::COORD_BITS - 1);
            quo_reg <= '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= diff;
            end
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[vnig_pkg::COORD_BITS-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

### design/vnig_front.sv
// Front end: accepts items, checks the grid bound, splits the index into x, y, z, builds the mask.
module vnig_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [vnig_pkg::CMD_W-1:0]       s_cmd,
    input  logic [vnig_pkg::IDX_W-1:0]       s_point_index,
    input  logic [vnig_pkg::SIZE_W-1:0]      size_x,
    input  logic [vnig_pkg::SIZE_W-1:0]      size_y,
    input  logic [vnig_pkg::SIZE_W-1:0]      size_z,
    output logic                             job_valid,
    input  logic                             job_ready,
    output vnig_pkg::job_t                   job
);

    vnig_pkg::front_state_t               state_reg;
    vnig_pkg::front_state_t               state_next;
    logic [vnig_pkg::CMD_W-1:0]           cmd_reg;
    logic [vnig_pkg::IDX_W-1:0]           idx_reg;
    logic [vnig_pkg::EFF_W-1:0]           sx_reg;
    logic [vnig_pkg::EFF_W-1:0]           sy_reg;
    logic [vnig_pkg::EFF_W-1:0]           sz_reg;
    logic [vnig_pkg::SXY_W-1:0]           sxy_reg;
    logic [vnig_pkg::TOT_W-1:0]           tot_reg;
    logic                                 oog_reg;
    logic [vnig_pkg::COORD_BITS-1:0]      x_reg;
    logic [vnig_pkg::COORD_BITS-1:0]      y_reg;
    logic [vnig_pkg::COORD_BITS-1:0]      z_reg;
    logic                                 oog_c;
    logic                                 accept;
    logic [vnig_pkg::NBR_MAX-1:0]         mask_c;
    vnig_pkg::div_req_t                   div_req;
    vnig_pkg::div_rsp_t                   div_rsp;

    vnig_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign oog_c  = (vnig_pkg::CMP_W'(idx_reg) >= vnig_pkg::CMP_W'(tot_reg));
    assign accept = s_tvalid && s_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vnig_pkg::F_IDLE: if (s_tvalid) state_next = vnig_pkg::F_MUL;
            vnig_pkg::F_MUL:  state_next = vnig_pkg::F_TOT;
            vnig_pkg::F_TOT:  state_next = vnig_pkg::F_CHK;
            vnig_pkg::F_CHK:  state_next = oog_c ? vnig_pkg::F_PUSH : vnig_pkg::F_DIVZ;
            vnig_pkg::F_DIVZ: if (div_rsp.done) state_next = vnig_pkg::F_DIVY;
            vnig_pkg::F_DIVY: if (div_rsp.done) state_next = vnig_pkg::F_PUSH;
            vnig_pkg::F_PUSH: begin
                if (job_ready) begin
                    state_next = s_tvalid ? vnig_pkg::F_MUL : vnig_pkg::F_IDLE;
                end
            end
            default: state_next = vnig_pkg::F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready    = 1'b0;
        job_valid   = 1'b0;
        div_req     = '{start: 1'b0, num: '0, den: '0};
        case (state_reg)
            vnig_pkg::F_IDLE: s_tready = 1'b1;
            vnig_pkg::F_CHK: begin
                // z = idx / (sx*sy)
                div_req.start = !oog_c;
                div_req.num   = vnig_pkg::DIV_W'(vnig_pkg::CMP_W'(idx_reg));
                div_req.den   = sxy_reg;
            end
            vnig_pkg::F_DIVZ: begin
                // y = rem / sx, x = remainder
                div_req.start = div_rsp.done;
                div_req.num   = div_rsp.rem;
                div_req.den   = vnig_pkg::SXY_W'(sx_reg);
            end
            vnig_pkg::F_PUSH: begin
                job_valid = 1'b1;
                s_tready  = job_ready;
            end
            default: s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vnig_pkg::F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_cmd;
            idx_reg <= s_point_index;
            sx_reg  <= vnig_pkg::eff_size(size_x);
            sy_reg  <= vnig_pkg::eff_size(size_y);
            sz_reg  <= vnig_pkg::eff_size(size_z);
        end
        if (state_reg == vnig_pkg::F_MUL) begin
            sxy_reg <= vnig_pkg::SXY_W'(sx_reg * sy_reg);
        end
        if (state_reg == vnig_pkg::F_TOT) begin
            tot_reg <= vnig_pkg::TOT_W'(sxy_reg * sz_reg);
        end
        if (state_reg == vnig_pkg::F_CHK) begin
            oog_reg <= oog_c;
        end
        if (state_reg == vnig_pkg::F_DIVZ && div_rsp.done) begin
            z_reg <= div_rsp.quo;
        end
        if (state_reg == vnig_pkg::F_DIVY && div_rsp.done) begin
            y_reg <= div_rsp.quo;
            x_reg <= vnig_pkg::COORD_BITS'(div_rsp.rem);
        end
    end

    // one bit per candidate of the mode's list
    always_comb begin
        for (int k = 0; k < vnig_pkg::NBR_MAX; k++) begin
            mask_c[k] = vnig_pkg::nbr_in_grid(cmd_reg, vnig_pkg::NBR_IDX_W'(k),
                                              x_reg, y_reg, z_reg,
                                              sx_reg, sy_reg, sz_reg);
        end
    end

    assign job.oog  = oog_reg;
    assign job.cmd  = cmd_reg;
    assign job.idx  = idx_reg;
    assign job.mask = oog_reg ? '0 : mask_c;
    assign job.sx   = sx_reg;
    assign job.sxy  = sxy_reg;

`ifndef SYNTHESIS
    a_div_done_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == vnig_pkg::F_DIVZ || state_reg == vnig_pkg::F_DIVY))
        else $error("divider result arrived outside a divide step");
`endif

endmodule

### design/vnig_queue.sv
// Short queue of classified items between front and back.
module vnig_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  vnig_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output vnig_pkg::job_t pop_job
);

    vnig_pkg::job_t                  entries_reg [vnig_pkg::QUEUE_DEPTH];
    logic [vnig_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [vnig_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [vnig_pkg::QCNT_W-1:0]     cnt_reg;
    logic [vnig_pkg::QCNT_W-1:0]     cnt_next;
    logic                            push;
    logic                            pop;

    assign push_ready = (cnt_reg != vnig_pkg::QCNT_W'(vnig_pkg::QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = entries_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + vnig_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - vnig_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == vnig_pkg::QPTR_W'(vnig_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + vnig_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == vnig_pkg::QPTR_W'(vnig_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + vnig_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= vnig_pkg::QCNT_W'(vnig_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

### design/vnig_back.sv
// Back end: walks the candidate mask into the output register, one index per unstalled cycle.
module vnig_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              job_valid,
    output logic                              job_ready,
    input  vnig_pkg::job_t                    job,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [vnig_pkg::M_DATA_W-1:0]     m_tdata,
    output logic [vnig_pkg::M_USER_W-1:0]     m_tuser,
    output logic                              m_tlast
);

    logic [vnig_pkg::NBR_MAX-1:0]     done_reg;
    logic [vnig_pkg::NBR_MAX-1:0]     rem;
    logic [vnig_pkg::NBR_MAX-1:0]     pick;
    logic [vnig_pkg::NBR_IDX_W-1:0]   k;
    logic                             marker;
    logic                             last;
    logic                             load;
    vnig_pkg::offs_t                  offs;
    logic [vnig_pkg::CMP_W-1:0]       step_x;
    logic [vnig_pkg::CMP_W-1:0]       step_y;
    logic [vnig_pkg::CMP_W-1:0]       step_z;
    logic [vnig_pkg::CMP_W-1:0]       sum;
    logic                             m_valid_reg;
    logic [vnig_pkg::IDX_W-1:0]       m_idx_reg;
    logic                             m_present_reg;
    logic                             m_oog_reg;
    logic                             m_last_reg;

    assign rem    = job.mask & ~done_reg;
    assign pick   = rem & (~rem + vnig_pkg::NBR_MAX'(1));   // lowest pending candidate
    assign marker = job.oog || (job.mask == '0);
    assign last   = marker || ((rem & ~pick) == '0);
    assign load   = job_valid && (!m_valid_reg || m_tready);
    assign job_ready = load && last;

    always_comb begin
        k = '0;
        for (int i = 0; i < vnig_pkg::NBR_MAX; i++) begin
            if (pick[i]) begin
                k = vnig_pkg::NBR_IDX_W'(i);
            end
        end
    end

    assign offs = vnig_pkg::nbr_offs(job.cmd, k);

    // idx + dx + dy*sx + dz*sx*sy
    always_comb begin
        case (offs.dx)
            vnig_pkg::D_NEG: step_x = '1;
            vnig_pkg::D_POS: step_x = vnig_pkg::CMP_W'(1);
            default:         step_x = '0;
        endcase
        case (offs.dy)
            vnig_pkg::D_NEG: step_y = '0 - vnig_pkg::CMP_W'(job.sx);
            vnig_pkg::D_POS: step_y = vnig_pkg::CMP_W'(job.sx);
            default:         step_y = '0;
        endcase
        case (offs.dz)
            vnig_pkg::D_NEG: step_z = '0 - vnig_pkg::CMP_W'(job.sxy);
            vnig_pkg::D_POS: step_z = vnig_pkg::CMP_W'(job.sxy);
            default:         step_z = '0;
        endcase
    end

    assign sum = vnig_pkg::CMP_W'(job.idx) + step_x + step_y + step_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            done_reg    <= '0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                done_reg    <= last ? '0 : (done_reg | pick);
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_idx_reg     <= marker ? '0 : vnig_pkg::IDX_W'(sum);
            m_present_reg <= !marker;
            m_oog_reg     <= job.oog;
            m_last_reg    <= last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = vnig_pkg::M_DATA_W'(m_idx_reg);
    assign m_tuser  = {m_oog_reg, m_present_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_one_candidate: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !marker) |-> $onehot(pick))
        else $error("no single candidate picked for a neighbour result");
    a_pop_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        job_ready |=> (m_tvalid && m_tlast))
        else $error("item released without a final result");
`endif

endmodule

### design/voxel_neighbour_index_generator.sv
// Top level of the voxel neighbour index generator: config registers, front, queue, back.
//
//  channel   dir  handshake              payload
//  s_        in   s_tvalid / s_tready    s_tdata: point_index; s_tuser: cmd
//  m_        out  m_tvalid / m_tready    m_tdata: neighbour_index;
//                                        m_tuser: present, out_of_grid; m_tlast: last
//  cfg_      in   cfg_valid / cfg_ready  cfg_index: register, cfg_data: value
//
// Front: an in-grid item makes the two passes of the bit-serial divider, z first and then y, x;
//   an index outside the grid skips them. The front takes no new item until the last is queued.
// Back: one result per cycle while the output is not stalled, 1 to 27 results per item.
// The front and the back work on different items at once; a 2-item queue decouples them.
// Reset is synchronous on aresetn low; sizes reset to 1. No clearing pass.
// m_tready low holds the output register; the back and then the front stall behind it.
module voxel_neighbour_index_generator (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [vnig_pkg::S_DATA_W-1:0]     s_tdata,   // [29:0] point_index, [31:30] zero
    input  logic [vnig_pkg::S_USER_W-1:0]     s_tuser,   // [2:0] cmd
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [vnig_pkg::M_DATA_W-1:0]     m_tdata,   // [29:0] neighbour_index, [31:30] zero
    output logic [vnig_pkg::M_USER_W-1:0]     m_tuser,   // [0] present, [1] out_of_grid
    output logic                              m_tlast,
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vnig_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vnig_pkg::SIZE_W-1:0]       cfg_data
);

    logic [vnig_pkg::SIZE_W-1:0] size_x_reg;
    logic [vnig_pkg::SIZE_W-1:0] size_y_reg;
    logic [vnig_pkg::SIZE_W-1:0] size_z_reg;
    logic                        fq_valid;
    logic                        fq_ready;
    vnig_pkg::job_t              fq_job;
    logic                        qb_valid;
    logic                        qb_ready;
    vnig_pkg::job_t              qb_job;

    // writes are always taken; an index past the last register is dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= vnig_pkg::SIZE_W'(1);
            size_y_reg <= vnig_pkg::SIZE_W'(1);
            size_z_reg <= vnig_pkg::SIZE_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                vnig_pkg::REG_SIZE_X: size_x_reg <= cfg_data;
                vnig_pkg::REG_SIZE_Y: size_y_reg <= cfg_data;
                vnig_pkg::REG_SIZE_Z: size_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    vnig_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_cmd         (s_tuser),
        .s_point_index (s_tdata[vnig_pkg::IDX_W-1:0]),
        .size_x        (size_x_reg),
        .size_y        (size_y_reg),
        .size_z        (size_z_reg),
        .job_valid     (fq_valid),
        .job_ready     (fq_ready),
        .job           (fq_job)
    );

    vnig_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    vnig_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
